>>> sv/pfx_pkg.sv
// Shared definitions for the postfix expression evaluator.
// Field widths, status codes, character codes and the controller/datapath bundles.
// No dependencies.
package pfx_pkg;

  localparam int DATA_W          = 32;
  localparam int CHAR_W          = 8;
  localparam int STATUS_W        = 3;
  localparam int DEPTH_W         = 5;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                take_in;
    logic                acc_step;
    logic                push_num;
    logic                set_err;
    logic [STATUS_W-1:0] err_code;
    logic                op_read;
    logic                op_exec;
    logic                div_start;
    logic                op_write;
    logic                read_top;
    logic                emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic last;
    logic err;
    logic in_number;
    logic full;
    logic lt2;
    logic rhs_zero;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> sv/pfx_div.sv
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on pfx_pkg for the data width.
module pfx_div import pfx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem_r, quo_r, den_r;
  logic              neg_r, run_r, done_r;
  logic [STEP_W-1:0] step_r;
  logic [DATA_W:0]   shifted, trial;

  always_comb begin
    shifted = {rem_r, quo_r[DATA_W-1]};
    trial   = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DATA_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands are held as magnitudes; the sign is put back on the way out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      den_r <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      rem_r <= '0;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (run_r) begin
      if (!trial[DATA_W]) begin
        rem_r <= trial[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule

>>> sv/pfx_dpath.sv
// Datapath: input holding register, digit accumulator, operand stack memory,
// arithmetic unit with divider, and the result register. Depends on pfx_pkg and pfx_div.
module pfx_dpath import pfx_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic [CHAR_W-1:0]          in_char_byte,
  input  logic                       in_last_char,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic signed [DATA_W-1:0]   out_value,
  output logic [STATUS_W-1:0]        out_status,
  output logic [DEPTH_W-1:0]         out_depth_left
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [CHAR_W-1:0]   char_r;
  logic                last_r;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic                in_num_r;
  logic [STATUS_W-1:0] err_r;
  logic [CNT_W-1:0]    cnt_r, cnt_m1, cnt_m2;
  logic [DATA_W-1:0]   mem [STACK_DEPTH];
  logic [DATA_W-1:0]   rhs_r, lhs_r, res_r, alu_res;
  logic                mem_we;
  logic [ADDR_W-1:0]   waddr;
  logic [DATA_W-1:0]   wdata;
  logic [3:0]          digit;
  op_t                 op;
  logic                is_op;
  logic                div_done;
  logic [DATA_W-1:0]   div_q;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_value_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [DEPTH_W-1:0]  out_depth_r;

  always_comb begin
    op    = OP_ADD;
    is_op = 1'b0;
    case (char_r)
      CH_PLUS: begin
        op    = OP_ADD;
        is_op = 1'b1;
      end
      CH_MINUS: begin
        op    = OP_SUB;
        is_op = 1'b1;
      end
      CH_STAR: begin
        op    = OP_MUL;
        is_op = 1'b1;
      end
      CH_SLASH: begin
        op    = OP_DIV;
        is_op = 1'b1;
      end
      default: begin
        op    = OP_ADD;
        is_op = 1'b0;
      end
    endcase
  end

  assign digit   = 4'(char_r - CH_ZERO);
  assign acc_nxt = (acc_r << 3) + (acc_r << 1) + DATA_W'(digit);
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign cnt_m2  = cnt_r - CNT_W'(2);

  always_comb begin
    stat.is_digit  = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
    stat.is_op     = is_op;
    stat.is_div    = (op == OP_DIV);
    stat.last      = last_r;
    stat.err       = (err_r != ST_OK);
    stat.in_number = in_num_r;
    stat.full      = (cnt_r == CNT_W'(STACK_DEPTH));
    stat.lt2       = (cnt_r < CNT_W'(2));
    stat.rhs_zero  = (rhs_r == '0);
    stat.div_done  = div_done;
    stat.out_busy  = out_valid_r && out_stall;
  end

  always_comb begin
    case (op)
      OP_ADD:  alu_res = lhs_r + rhs_r;
      OP_SUB:  alu_res = lhs_r - rhs_r;
      OP_MUL:  alu_res = lhs_r * rhs_r;
      default: alu_res = lhs_r + rhs_r;
    endcase
  end

  pfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lhs_r),
    .divisor  (rhs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Stack memory: one write port, reads at the top and the entry beneath it.
  always_comb begin
    mem_we = (cmd.push_num && !stat.full) || cmd.op_write;
    waddr  = cmd.op_write ? cnt_m2[ADDR_W-1:0] : cnt_r[ADDR_W-1:0];
    wdata  = cmd.op_write ? res_r : acc_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.op_read || cmd.read_top) begin
      rhs_r <= mem[cnt_m1[ADDR_W-1:0]];
      lhs_r <= mem[cnt_m2[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      char_r <= in_char_byte;
      last_r <= in_last_char;
    end
    if (cmd.op_exec) begin
      res_r <= alu_res;
    end else if (div_done) begin
      res_r <= div_q;
    end
    if (cmd.emit) begin
      if (err_r != ST_OK) begin
        out_value_r  <= '0;
        out_status_r <= err_r;
        out_depth_r  <= '0;
      end else if (cnt_r == '0) begin
        out_value_r  <= '0;
        out_status_r <= ST_EMPTY;
        out_depth_r  <= '0;
      end else begin
        out_value_r  <= rhs_r;
        out_status_r <= ST_OK;
        out_depth_r  <= DEPTH_W'(cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      in_num_r    <= 1'b0;
      err_r       <= ST_OK;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc_step) begin
        acc_r    <= acc_nxt;
        in_num_r <= 1'b1;
      end
      if (cmd.push_num) begin
        acc_r    <= '0;
        in_num_r <= 1'b0;
        if (!stat.full) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.op_write) begin
        cnt_r <= cnt_m1;
      end
      if (cmd.set_err) begin
        if (err_r == ST_OK) begin
          err_r <= cmd.err_code;
        end
        cnt_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        acc_r       <= '0;
        in_num_r    <= 1'b0;
        err_r       <= ST_OK;
        cnt_r       <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_status     = out_status_r;
  assign out_depth_left = out_depth_r;

endmodule

>>> sv/pfx_ctrl.sv
// Controller state machine: steps each character through push, operator and end handling.
// Depends on pfx_pkg for the command and status bundles.
module pfx_ctrl import pfx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASSIFY,
    S_PUSH,
    S_OP_CHK,
    S_OP_READ,
    S_OP_DIV,
    S_OP_WRITE,
    S_LAST_CHK,
    S_READ_TOP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (stat.err) begin
          state_nxt = S_LAST_CHK;
        end else if (stat.is_digit) begin
          cmd.acc_step = 1'b1;
          state_nxt    = S_LAST_CHK;
        end else if (stat.in_number) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_OP_CHK;
        end
      end
      S_PUSH: begin
        cmd.push_num = 1'b1;
        if (stat.full) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_OVER;
        end
        state_nxt = S_OP_CHK;
      end
      S_OP_CHK: begin
        if (stat.err || !stat.is_op) begin
          state_nxt = S_LAST_CHK;
        end else if (stat.lt2) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_UNDER;
          state_nxt    = S_LAST_CHK;
        end else begin
          cmd.op_read = 1'b1;
          state_nxt   = S_OP_READ;
        end
      end
      S_OP_READ: begin
        if (stat.is_div && stat.rhs_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIVZ;
          state_nxt    = S_LAST_CHK;
        end else if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_OP_DIV;
        end else begin
          cmd.op_exec = 1'b1;
          state_nxt   = S_OP_WRITE;
        end
      end
      S_OP_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_OP_WRITE;
        end
      end
      S_OP_WRITE: begin
        cmd.op_write = 1'b1;
        state_nxt    = S_LAST_CHK;
      end
      S_LAST_CHK: begin
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (stat.in_number && !stat.err) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_READ_TOP;
        end
      end
      S_READ_TOP: begin
        cmd.read_top = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

>>> sv/postfix_expression_evaluator.sv
// Postfix expression evaluator: one character beat in, one result beat per expression.
// Each character steps through the controller states; a division waits for the divider,
// and the last character may wait further while the previous result is still held.
// Characters are taken one at a time; the next beat is taken once the previous finishes.
// Reset (rst_n, synchronous, active low) empties the stack and clears the error state.
module postfix_expression_evaluator import pfx_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CHAR_W-1:0]        in_char_byte,
  input  logic                     in_last_char,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value,
  output logic [STATUS_W-1:0]      out_status,
  output logic [DEPTH_W-1:0]       out_depth_left
);

  // The controller owns sequencing and the input handshake; the datapath owns all
  // stored values, including the result register, so a finished result can wait
  // for the downstream side while the next character beat is already being taken.
  // The stack memory itself is not cleared at reset and needs no clearing pass,
  // because only entries below the count are ever used.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  pfx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the operand stack as a memory of STACK_DEPTH words. Errors
  // are sticky: the first one is kept, the stack is emptied and later characters
  // are ignored until the last one, whose result carries the error code.
  pfx_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_char_byte   (in_char_byte),
    .in_last_char   (in_last_char),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_depth_left (out_depth_left)
  );

endmodule
